### rtl/bvrc_pkg.sv
// Shared definitions for the byte vocabulary rank coder.
// Action and error codes, map geometry, scan interface types and a popcount helper.
// No dependencies.
package bvrc_pkg;

  localparam int unsigned MAP_BITS = 256;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned ROWS     = MAP_BITS / ROW_W;
  localparam int unsigned ROW_AW   = $clog2(ROWS);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LEARN  = 2'd1;
  localparam logic [1:0] ACT_ENCODE = 2'd2;
  localparam logic [1:0] ACT_DECODE = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_BAD_ID  = 2'd2;

  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  typedef struct packed {
    logic       start;
    logic       decode;
    logic [7:0] key;
  } scan_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
  } scan_rsp_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/byte_vocabulary_rank_coder_core.sv
// Byte vocabulary rank coder, top level.
// Holds the 256-bit seen map and distinct count; uses bvrc_scan and bvrc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries action, byte_value, token_id
//   and last_in. Output channel (out_valid_o / out_ready_i) returns one result
//   per input transfer: id_out, byte_out, error_code, vocab_size, last_out.
//   Clear, learn, and encode/decode that end in an error need no scan:
//   the result is registered at the accepting edge and valid the next cycle.
//   A successful encode or decode runs a rank/select scan over the map, one
//   8-bit row per cycle over all 32 rows; its result is loaded into the output
//   register once the scan is done and the output register is free. One item
//   is in flight at a time: no input is taken while a scan is pending.
//   A held result in the output register does not block an input transfer if
//   the receiver takes it in the same cycle; otherwise in_ready_o stays low
//   until out_ready_i rises.
//   Reset clears the map, the count and all handshake state at once.
module byte_vocabulary_rank_coder_core import bvrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] token_id_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] id_out_o,
  output logic [7:0] byte_out_o,
  output logic [1:0] error_code_o,
  output logic [8:0] vocab_size_o,
  output logic       last_out_o
);

  logic [7:0] map_q [ROWS];
  logic [8:0] count_q;
  logic       pend_q;
  logic       pend_dec_q;
  logic       pend_last_q;

  logic       out_valid_q;
  logic [7:0] id_q;
  logic [7:0] byte_q;
  logic [1:0] err_q;
  logic [8:0] vs_q;
  logic       last_q;

  logic              in_fire;
  logic              out_free;
  logic              seen;
  logic              id_ok;
  logic              need_scan;
  logic              scan_load;
  logic [ROW_AW-1:0] row_idx;
  scan_req_t         req;
  scan_rsp_t         rsp;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign seen  = map_q[byte_value_i[7:3]][byte_value_i[2:0]];
  assign id_ok = {1'b0, token_id_i} < count_q;

  always_comb begin
    case (action_i)
      ACT_ENCODE: need_scan = seen;
      ACT_DECODE: need_scan = id_ok;
      default:    need_scan = 1'b0;
    endcase
  end

  assign req.start  = in_fire && need_scan;
  assign req.decode = (action_i == ACT_DECODE);
  assign req.key    = (action_i == ACT_DECODE) ? token_id_i : byte_value_i;

  assign scan_load = pend_q && rsp.done && out_free;

  bvrc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .row_i     (map_q[row_idx]),
    .row_idx_o (row_idx),
    .rsp_o     (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        map_q[r] <= '0;
      end
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && action_i == ACT_CLEAR) begin
        for (int r = 0; r < ROWS; r++) begin
          map_q[r] <= '0;
        end
        count_q <= '0;
      end else if (in_fire && action_i == ACT_LEARN && !seen) begin
        map_q[byte_value_i[7:3]][byte_value_i[2:0]] <= 1'b1;
        count_q <= count_q + 9'd1;
      end

      if (req.start) begin
        pend_q <= 1'b1;
      end else if (scan_load) begin
        pend_q <= 1'b0;
      end

      if ((in_fire && !need_scan) || scan_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.start) begin
      pend_dec_q  <= req.decode;
      pend_last_q <= last_in_i;
    end
    if (scan_load) begin
      id_q   <= pend_dec_q ? 8'd0 : rsp.result;
      byte_q <= pend_dec_q ? rsp.result : 8'd0;
      err_q  <= ERR_NONE;
      vs_q   <= count_q;
      last_q <= pend_last_q;
    end else if (in_fire && !need_scan) begin
      id_q   <= 8'd0;
      byte_q <= 8'd0;
      last_q <= last_in_i;
      case (action_i)
        ACT_CLEAR: begin
          err_q <= ERR_NONE;
          vs_q  <= '0;
        end
        ACT_LEARN: begin
          err_q <= ERR_NONE;
          vs_q  <= seen ? count_q : count_q + 9'd1;
        end
        ACT_ENCODE: begin
          err_q <= ERR_UNKNOWN;
          vs_q  <= count_q;
        end
        default: begin
          err_q <= ERR_BAD_ID;
          vs_q  <= count_q;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign id_out_o     = id_q;
  assign byte_out_o   = byte_q;
  assign error_code_o = err_q;
  assign vocab_size_o = vs_q;
  assign last_out_o   = last_q;

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("input taken during scan");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 9'd256)
    else $error("distinct count out of range");

  a_learn_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == ACT_LEARN && !seen) |=> count_q == $past(count_q) + 9'd1)
    else $error("learn of new byte did not bump count");

  a_bad_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_NONE) |-> (id_out_o == 8'd0 && byte_out_o == 8'd0))
    else $error("error result carries data");

endmodule

### rtl/bvrc_scan.sv
// Rank / select scan over the seen map, one 8-bit row per cycle.
// Encode: counts seen bytes below the key. Decode: finds the byte of rank key.
// Depends on bvrc_pkg.
module bvrc_scan import bvrc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_req_t         req_i,
  input  logic [7:0]        row_i,
  output logic [ROW_AW-1:0] row_idx_o,
  output scan_rsp_t         rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic              decode_q;
  logic              found_q;
  logic [7:0]        key_q;
  logic [ROW_AW-1:0] cnt_q;
  logic [8:0]        acc_q;
  logic [7:0]        res_q;

  logic [7:0] mask;
  logic [8:0] sum;
  logic [2:0] rem;
  logic [2:0] pos;
  logic [3:0] seen_n;
  logic       pos_hit;
  logic       hit;

  always_comb begin
    if (decode_q) begin
      mask = 8'hFF;
    end else if (cnt_q < key_q[7:3]) begin
      mask = 8'hFF;
    end else if (cnt_q == key_q[7:3]) begin
      mask = (8'd1 << key_q[2:0]) - 8'd1;
    end else begin
      mask = 8'h00;
    end
  end

  assign sum = acc_q + 9'(popcnt8(row_i & mask));
  assign rem = 3'(key_q - acc_q[7:0]);
  assign hit = decode_q && !found_q && (sum > {1'b0, key_q});

  // position of the rem-th set bit in the current row
  always_comb begin
    pos     = '0;
    seen_n  = '0;
    pos_hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (row_i[i]) begin
        if (!pos_hit && seen_n == {1'b0, rem}) begin
          pos     = 3'(i);
          pos_hit = 1'b1;
        end
        seen_n = seen_n + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      decode_q <= 1'b0;
      found_q  <= 1'b0;
      key_q    <= '0;
      cnt_q    <= '0;
      acc_q    <= '0;
    end else if (req_i.start) begin
      busy_q   <= 1'b1;
      done_q   <= 1'b0;
      decode_q <= req_i.decode;
      found_q  <= 1'b0;
      key_q    <= req_i.key;
      cnt_q    <= '0;
      acc_q    <= '0;
    end else if (busy_q) begin
      acc_q <= sum;
      cnt_q <= cnt_q + 1'b1;
      if (hit) begin
        found_q <= 1'b1;
      end
      if (cnt_q == LAST_ROW) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && hit) begin
      res_q <= {cnt_q, pos};
    end
  end

  assign row_idx_o    = cnt_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = decode_q ? res_q : acc_q[7:0];

endmodule
